// ===== hw/rtl/lho_pkg.sv =====
// Package for the Lorenz Heun oscillator: widths, reset constants, datapath codes,
// the microprogram and the saturation and clamp helpers.
// Has no dependencies; every module of the block imports it.
package lho_pkg;

   localparam int DATA_W  = 32;
   localparam int FRAC_W  = 22;
   localparam int FRAC1_W = FRAC_W + 1;
   localparam int OPND_W  = DATA_W + 1;
   localparam int PROD_W  = 2 * OPND_W;
   localparam int PHASE_W = 24;
   localparam int STEP_W  = 5;
   localparam int CSR_W   = 3;
   localparam int DIM_W   = 2;

   localparam logic [FRAC1_W-1:0] ONE_Q = {1'b1, {FRAC_W{1'b0}}};

   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic signed [DATA_W-1:0] POS_RESET    = 32'sd419430;
   localparam logic signed [DATA_W-1:0] COEF_A_RESET = 32'sd41943040;
   localparam logic signed [DATA_W-1:0] COEF_R_RESET = 32'sd117440512;
   localparam logic signed [DATA_W-1:0] COEF_C_RESET = 32'sd11198792;
   localparam logic [FRAC1_W-1:0]       DT_RESET     = 23'd41943;

   localparam logic [CSR_W-1:0] CSR_COEF_A      = 3'd0;
   localparam logic [CSR_W-1:0] CSR_COEF_R      = 3'd1;
   localparam logic [CSR_W-1:0] CSR_COEF_C      = 3'd2;
   localparam logic [CSR_W-1:0] CSR_STEP_DT     = 3'd3;
   localparam logic [CSR_W-1:0] CSR_DIM_SELECT  = 3'd4;
   localparam logic [CSR_W-1:0] CSR_INTERP_STEP = 3'd5;

   localparam logic [DIM_W-1:0] DIM_X = 2'd0;
   localparam logic [DIM_W-1:0] DIM_Y = 2'd1;
   localparam logic [DIM_W-1:0] DIM_Z = 2'd2;

   localparam logic [STEP_W-1:0] L_INTERP = 5'd24;
   localparam logic [STEP_W-1:0] L_DIRECT = 5'd26;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef enum logic [4:0] {
      SRC_ZERO,
      SRC_PX, SRC_PY, SRC_PZ,
      SRC_EX, SRC_EY, SRC_EZ,
      SRC_FX, SRC_FY, SRC_FZ,
      SRC_GX, SRC_GY, SRC_GZ,
      SRC_T0, SRC_T1,
      SRC_CA, SRC_CR, SRC_CC, SRC_DT,
      SRC_PH, SRC_DL, SRC_SV, SRC_TG, SRC_SEL,
      SRC_QP, SRC_HP, SRC_IP
   } src_type;

   typedef enum logic [4:0] {
      DST_PX, DST_PY, DST_PZ,
      DST_EX, DST_EY, DST_EZ,
      DST_FX, DST_FY, DST_FZ,
      DST_GX, DST_GY, DST_GZ,
      DST_T0, DST_T1,
      DST_SV, DST_TG, DST_DL,
      DST_OUT
   } dst_type;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_ADDW,
      OP_SUBW
   } alu_op_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_NOSTEP,
      COND_NOINTERP
   } cond_type;

   typedef struct packed {
      logic              mul_en;
      src_type           mul_a;
      src_type           mul_b;
      logic              alu_en;
      alu_op_type        op;
      src_type           alu_a;
      src_type           alu_b;
      dst_type           dst;
      cond_type          cond;
      logic [STEP_W-1:0] target;
      logic              last;
   } uword_type;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      src_type    mul_a;
      src_type    mul_b;
      logic       alu_en;
      alu_op_type op;
      src_type    alu_a;
      src_type    alu_b;
      dst_type    dst;
   } ctrl_type;

   function automatic logic signed [OPND_W-1:0] sat_data(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(SAT_MAX);
      lo = PROD_W'(SAT_MIN);
      if (v > hi) begin
         return OPND_W'(SAT_MAX);
      end else if (v < lo) begin
         return OPND_W'(SAT_MIN);
      end
      return v[OPND_W-1:0];
   endfunction

   function automatic logic [FRAC1_W-1:0] clamp_one(input logic [DATA_W-1:0] v);
      logic [FRAC1_W-1:0] s;
      s = v[FRAC1_W-1:0];
      return (s > ONE_Q) ? ONE_Q : s;
   endfunction

   function automatic uword_type with_mul(input uword_type w, input src_type a,
                                          input src_type b);
      uword_type r;
      r        = w;
      r.mul_en = 1'b1;
      r.mul_a  = a;
      r.mul_b  = b;
      return r;
   endfunction

   function automatic uword_type with_alu(input uword_type w, input alu_op_type op,
                                          input src_type a, input src_type b,
                                          input dst_type d);
      uword_type r;
      r        = w;
      r.alu_en = 1'b1;
      r.op     = op;
      r.alu_a  = a;
      r.alu_b  = b;
      r.dst    = d;
      return r;
   endfunction

   function automatic uword_type with_jump(input uword_type w, input cond_type c,
                                           input logic [STEP_W-1:0] t);
      uword_type r;
      r        = w;
      r.cond   = c;
      r.target = t;
      return r;
   endfunction

   function automatic uword_type with_last(input uword_type w);
      uword_type r;
      r      = w;
      r.last = 1'b1;
      return r;
   endfunction

   // Heun step in steps 0 to 20, interpolation bookkeeping after it, and the two
   // output tails. A product is available to the step after its multiply.
   function automatic uword_type ucode(input logic [STEP_W-1:0] addr);
      uword_type w;
      w        = '0;
      w.mul_a  = SRC_ZERO;
      w.mul_b  = SRC_ZERO;
      w.op     = OP_ADD;
      w.alu_a  = SRC_ZERO;
      w.alu_b  = SRC_ZERO;
      w.dst    = DST_T0;
      w.cond   = COND_NONE;
      case (addr)
         5'd0: w = with_jump(with_alu(w, OP_SUB, SRC_PY, SRC_PX, DST_T0),
                             COND_NOSTEP, L_INTERP);
         5'd1: w = with_alu(with_mul(w, SRC_CA, SRC_T0), OP_SUB, SRC_CR, SRC_PZ, DST_T1);
         5'd2: w = with_alu(with_mul(w, SRC_PX, SRC_T1), OP_ADD, SRC_QP, SRC_ZERO, DST_FX);
         5'd3: w = with_alu(with_mul(w, SRC_PX, SRC_PY), OP_SUB, SRC_QP, SRC_PY, DST_FY);
         5'd4: w = with_alu(with_mul(w, SRC_PZ, SRC_CC), OP_ADD, SRC_QP, SRC_ZERO, DST_T0);
         5'd5: w = with_alu(with_mul(w, SRC_DT, SRC_FX), OP_SUB, SRC_T0, SRC_QP, DST_FZ);
         5'd6: w = with_alu(with_mul(w, SRC_DT, SRC_FY), OP_ADD, SRC_PX, SRC_QP, DST_EX);
         5'd7: w = with_alu(with_mul(w, SRC_DT, SRC_FZ), OP_ADD, SRC_PY, SRC_QP, DST_EY);
         5'd8: w = with_alu(w, OP_SUB, SRC_EY, SRC_EX, DST_T0);
         5'd9: w = with_alu(with_mul(w, SRC_CA, SRC_T0), OP_ADD, SRC_PZ, SRC_QP, DST_EZ);
         5'd10: w = with_alu(with_mul(w, SRC_EX, SRC_EY), OP_ADD, SRC_QP, SRC_ZERO, DST_GX);
         5'd11: w = with_alu(with_mul(w, SRC_EZ, SRC_CC), OP_ADD, SRC_QP, SRC_ZERO, DST_T0);
         5'd12: w = with_alu(w, OP_SUB, SRC_CR, SRC_EZ, DST_T1);
         5'd13: w = with_alu(with_mul(w, SRC_EX, SRC_T1), OP_SUB, SRC_T0, SRC_QP, DST_GZ);
         5'd14: w = with_alu(w, OP_SUB, SRC_QP, SRC_EY, DST_GY);
         5'd15: w = with_alu(w, OP_ADDW, SRC_FZ, SRC_GZ, DST_GZ);
         5'd16: w = with_alu(w, OP_ADDW, SRC_FX, SRC_GX, DST_GX);
         5'd17: w = with_alu(with_mul(w, SRC_DT, SRC_GX), OP_ADDW, SRC_FY, SRC_GY, DST_GY);
         5'd18: w = with_alu(with_mul(w, SRC_DT, SRC_GY), OP_ADD, SRC_PX, SRC_HP, DST_PX);
         5'd19: w = with_alu(with_mul(w, SRC_DT, SRC_GZ), OP_ADD, SRC_PY, SRC_HP, DST_PY);
         5'd20: w = with_jump(with_alu(w, OP_ADD, SRC_PZ, SRC_HP, DST_PZ),
                              COND_NOINTERP, L_DIRECT);
         5'd21: w = with_alu(w, OP_ADD, SRC_TG, SRC_ZERO, DST_SV);
         5'd22: w = with_alu(w, OP_ADD, SRC_SEL, SRC_ZERO, DST_TG);
         5'd23: w = with_alu(w, OP_SUBW, SRC_TG, SRC_SV, DST_DL);
         5'd24: w = with_mul(w, SRC_PH, SRC_DL);
         5'd25: w = with_last(with_alu(w, OP_ADD, SRC_SV, SRC_IP, DST_OUT));
         5'd26: w = with_last(with_alu(w, OP_ADD, SRC_SEL, SRC_ZERO, DST_OUT));
         default: w = with_last(w);
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/lho_datapath.sv =====
// Datapath of the Lorenz Heun oscillator: working registers, one shared multiplier
// with a product register, and an adder that saturates or wraps. Depends on lho_pkg.
module lho_datapath
   import lho_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  ctrl_type                   ctrl,
   input  logic signed [DATA_W-1:0]   coef_a,
   input  logic signed [DATA_W-1:0]   coef_r,
   input  logic signed [DATA_W-1:0]   coef_c,
   input  logic [FRAC1_W-1:0]         step_dt,
   input  logic [DIM_W-1:0]           dim_select,
   input  logic [PHASE_W-1:0]         phase,
   input  logic signed [DATA_W-1:0]   load_x,
   input  logic signed [DATA_W-1:0]   load_y,
   input  logic signed [DATA_W-1:0]   load_z,
   output logic signed [DATA_W-1:0]   sample
);

   logic signed [OPND_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [OPND_W-1:0] ev_x_ff, ev_y_ff, ev_z_ff;
   logic signed [OPND_W-1:0] f_x_ff, f_y_ff, f_z_ff;
   logic signed [OPND_W-1:0] g_x_ff, g_y_ff, g_z_ff;
   logic signed [OPND_W-1:0] t0_ff, t1_ff;
   logic signed [OPND_W-1:0] src_ff, tgt_ff, dlt_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DATA_W-1:0] sample_ff;

   logic signed [PROD_W-1:0] prod_in;
   logic signed [OPND_W-1:0] alu_in;
   logic signed [OPND_W-1:0] mul_a, mul_b, alu_a, alu_b;
   logic signed [OPND_W-1:0] sel_val, qp_val, hp_val, ip_val;
   logic signed [PROD_W-1:0] prod_q, prod_h;
   logic signed [PROD_W-1:0] sum_wide;

   function automatic logic signed [OPND_W-1:0] src_value(input src_type s);
      logic signed [OPND_W-1:0] v;
      case (s)
         SRC_ZERO: v = '0;
         SRC_PX:   v = pos_x_ff;
         SRC_PY:   v = pos_y_ff;
         SRC_PZ:   v = pos_z_ff;
         SRC_EX:   v = ev_x_ff;
         SRC_EY:   v = ev_y_ff;
         SRC_EZ:   v = ev_z_ff;
         SRC_FX:   v = f_x_ff;
         SRC_FY:   v = f_y_ff;
         SRC_FZ:   v = f_z_ff;
         SRC_GX:   v = g_x_ff;
         SRC_GY:   v = g_y_ff;
         SRC_GZ:   v = g_z_ff;
         SRC_T0:   v = t0_ff;
         SRC_T1:   v = t1_ff;
         SRC_CA:   v = OPND_W'(coef_a);
         SRC_CR:   v = OPND_W'(coef_r);
         SRC_CC:   v = OPND_W'(coef_c);
         SRC_DT:   v = {{(OPND_W-FRAC1_W){1'b0}}, step_dt};
         SRC_PH:   v = {{(OPND_W-PHASE_W){1'b0}}, phase};
         SRC_DL:   v = dlt_ff;
         SRC_SV:   v = src_ff;
         SRC_TG:   v = tgt_ff;
         SRC_SEL:  v = sel_val;
         SRC_QP:   v = qp_val;
         SRC_HP:   v = hp_val;
         SRC_IP:   v = ip_val;
         default:  v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      case (dim_select)
         DIM_Y:   sel_val = pos_y_ff;
         DIM_Z:   sel_val = pos_z_ff;
         default: sel_val = pos_x_ff;
      endcase
   end

   assign prod_q = prod_ff >>> FRAC_W;
   assign prod_h = prod_ff >>> FRAC1_W;
   assign qp_val = sat_data(prod_q);
   assign hp_val = prod_h[OPND_W-1:0];
   assign ip_val = prod_q[OPND_W-1:0];

   always_comb begin
      mul_a    = src_value(ctrl.mul_a);
      mul_b    = src_value(ctrl.mul_b);
      alu_a    = src_value(ctrl.alu_a);
      alu_b    = src_value(ctrl.alu_b);
      prod_in  = PROD_W'(mul_a) * PROD_W'(mul_b);
      if (ctrl.op == OP_ADD || ctrl.op == OP_ADDW) begin
         sum_wide = PROD_W'(alu_a) + PROD_W'(alu_b);
      end else begin
         sum_wide = PROD_W'(alu_a) - PROD_W'(alu_b);
      end
      if (ctrl.op == OP_ADD || ctrl.op == OP_SUB) begin
         alu_in = sat_data(sum_wide);
      end else begin
         alu_in = sum_wide[OPND_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.alu_en) begin
         case (ctrl.dst)
            DST_EX:  ev_x_ff   <= alu_in;
            DST_EY:  ev_y_ff   <= alu_in;
            DST_EZ:  ev_z_ff   <= alu_in;
            DST_FX:  f_x_ff    <= alu_in;
            DST_FY:  f_y_ff    <= alu_in;
            DST_FZ:  f_z_ff    <= alu_in;
            DST_GX:  g_x_ff    <= alu_in;
            DST_GY:  g_y_ff    <= alu_in;
            DST_GZ:  g_z_ff    <= alu_in;
            DST_T0:  t0_ff     <= alu_in;
            DST_T1:  t1_ff     <= alu_in;
            DST_OUT: sample_ff <= alu_in[DATA_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= OPND_W'(POS_RESET);
         pos_y_ff <= OPND_W'(POS_RESET);
         pos_z_ff <= OPND_W'(POS_RESET);
         src_ff   <= '0;
         tgt_ff   <= '0;
         dlt_ff   <= '0;
      end else if (ctrl.load) begin
         pos_x_ff <= OPND_W'(load_x);
         pos_y_ff <= OPND_W'(load_y);
         pos_z_ff <= OPND_W'(load_z);
      end else if (ctrl.alu_en) begin
         case (ctrl.dst)
            DST_PX:  pos_x_ff <= alu_in;
            DST_PY:  pos_y_ff <= alu_in;
            DST_PZ:  pos_z_ff <= alu_in;
            DST_SV:  src_ff   <= alu_in;
            DST_TG:  tgt_ff   <= alu_in;
            DST_DL:  dlt_ff   <= alu_in;
            default: ;
         endcase
      end
   end

   assign sample = sample_ff;

endmodule

// ===== hw/rtl/lho_sequencer.sv =====
// Microprogram sequencer of the Lorenz Heun oscillator: request handshake, step
// counter with conditional jumps, phase accumulator and response flag. Uses lho_pkg.
module lho_sequencer
   import lho_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [FRAC1_W-1:0]   interp_step,
   output logic [PHASE_W-1:0]   phase,
   output ctrl_type             ctrl
);

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic                nostep_ff, nostep_in;
   logic                rsp_valid_ff, rsp_valid_in;

   uword_type           word;
   logic                interp_off;
   logic [PHASE_W-1:0]  phase_sum;
   logic                step_due;
   logic                slot_free;
   logic                take_jump;

   assign word       = ucode(step_ff);
   assign interp_off = (interp_step == '0);
   assign phase_sum  = phase_ff + PHASE_W'(interp_step);
   assign step_due   = (phase_sum >= PHASE_W'(ONE_Q));
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign take_jump  = (word.cond == COND_NOSTEP && nostep_ff) ||
                       (word.cond == COND_NOINTERP && interp_off);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         phase_ff     <= '0;
         nostep_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         nostep_ff    <= nostep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      nostep_in    = nostep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      ctrl         = '0;
      ctrl.mul_a   = word.mul_a;
      ctrl.mul_b   = word.mul_b;
      ctrl.op      = word.op;
      ctrl.alu_a   = word.alu_a;
      ctrl.alu_b   = word.alu_b;
      ctrl.dst     = word.dst;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode) begin
                  ctrl.load = 1'b1;
               end else begin
                  state_in  = ST_RUN;
                  step_in   = '0;
                  nostep_in = 1'b0;
                  if (!interp_off) begin
                     nostep_in = !step_due;
                     phase_in  = step_due ? phase_sum - PHASE_W'(ONE_Q) : phase_sum;
                  end
               end
            end
         end
         ST_RUN: begin
            if (!word.last || slot_free) begin
               ctrl.mul_en = word.mul_en;
               ctrl.alu_en = word.alu_en;
               if (word.last) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else if (take_jump) begin
                  step_in = word.target;
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign phase     = phase_ff;

endmodule

// ===== hw/rtl/lorenz_heun_oscillator.sv =====
// Lorenz Heun oscillator top level: configuration registers, sequencer and datapath.
// A load request loads the position and gives no response. A tick runs the Heun step of
// the microprogram, then with interpolation the bookkeeping and interpolation tail; an
// interpolated tick that does not step runs only that tail. Its response rises as the
// sequencer returns to idle for the next request. All products share one multiplier.
// Reset (synchronous) restores default coefficients, position 0.1 and clears phase.
module lorenz_heun_oscillator
   import lho_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_mode,
   input  logic signed [DATA_W-1:0]   req_load_x,
   input  logic signed [DATA_W-1:0]   req_load_y,
   input  logic signed [DATA_W-1:0]   req_load_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [DATA_W-1:0]   rsp_sample,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_W-1:0]           csr_index,
   input  logic [DATA_W-1:0]          csr_wdata
);

   logic signed [DATA_W-1:0] coef_a_ff, coef_r_ff, coef_c_ff;
   logic [FRAC1_W-1:0]       step_dt_ff, interp_step_ff;
   logic [DIM_W-1:0]         dim_select_ff;

   logic [PHASE_W-1:0]       phase;
   ctrl_type                 ctrl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff      <= COEF_A_RESET;
         coef_r_ff      <= COEF_R_RESET;
         coef_c_ff      <= COEF_C_RESET;
         step_dt_ff     <= DT_RESET;
         dim_select_ff  <= DIM_X;
         interp_step_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_COEF_A:      coef_a_ff      <= csr_wdata;
            CSR_COEF_R:      coef_r_ff      <= csr_wdata;
            CSR_COEF_C:      coef_c_ff      <= csr_wdata;
            CSR_STEP_DT:     step_dt_ff     <= clamp_one(csr_wdata);
            CSR_DIM_SELECT:  dim_select_ff  <= csr_wdata[DIM_W-1:0];
            CSR_INTERP_STEP: interp_step_ff <= clamp_one(csr_wdata);
            default: ;
         endcase
      end
   end

   lho_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .interp_step (interp_step_ff),
      .phase       (phase),
      .ctrl        (ctrl)
   );

   lho_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .coef_a     (coef_a_ff),
      .coef_r     (coef_r_ff),
      .coef_c     (coef_c_ff),
      .step_dt    (step_dt_ff),
      .dim_select (dim_select_ff),
      .phase      (phase),
      .load_x     (req_load_x),
      .load_y     (req_load_y),
      .load_z     (req_load_z),
      .sample     (rsp_sample)
   );

   // A load request never produces a response.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode && !rsp_valid) |=> !rsp_valid)
      else $error("load request produced a response");

   // A tick occupies the sequencer, so no request is taken in the next cycle.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_mode) |=> !req_ready)
      else $error("request taken while a tick is being computed");

   // A new response only appears as the sequencer returns to idle.
   a_rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("response raised while the sequencer is still running");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for lorenz_heun_oscillator: directed and random position loads and
// sample ticks, checked against an in-bench Heun integrator, with random idling on
// the request and response ports. Depends only on lho_pkg and the oscillator RTL.
module tb_top;
   import lho_pkg::*;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   localparam logic [CSR_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam longint UNIT_Q = longint'(1) << FRAC_W;
   localparam logic [DATA_W-1:0] ONE_WORD = DATA_W'(UNIT_Q);
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS = 100;
   localparam int RANDOM_PHASES = 8;

   typedef struct packed {
      logic                     mode;
      logic signed [DATA_W-1:0] load_x;
      logic signed [DATA_W-1:0] load_y;
      logic signed [DATA_W-1:0] load_z;
   } lorenz_req_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_mode = MODE_TICK;
   logic signed [DATA_W-1:0] req_load_x = '0;
   logic signed [DATA_W-1:0] req_load_y = '0;
   logic signed [DATA_W-1:0] req_load_z = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_sample;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_W-1:0]         csr_index = '0;
   logic [DATA_W-1:0]        csr_wdata = '0;

   // Register copies and oscillator state of the bench's own integrator.
   longint           sigma = COEF_A_RESET;
   longint           rho = COEF_R_RESET;
   longint           beta = COEF_C_RESET;
   longint           dt_q = DT_RESET;
   logic [DIM_W-1:0] dim_sel = DIM_X;
   longint           interp_inc = 0;
   longint           pos_x = POS_RESET;
   longint           pos_y = POS_RESET;
   longint           pos_z = POS_RESET;
   longint           phase_q = 0;
   longint           src_val = 0;
   longint           tgt_val = 0;
   longint           dlt_val = 0;

   lorenz_req_type           pending[$];
   logic signed [DATA_W-1:0] awaited_samples[$];

   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;
   int req_gap = 0;
   int rsp_stall = 0;
   int requests_taken = 0;
   int loads_taken = 0;
   int samples_checked = 0;
   int csr_writes = 0;
   int settings_used = 1;
   int fault_count = 0;

   lorenz_heun_oscillator dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_mode   (req_mode),
      .req_load_x (req_load_x),
      .req_load_y (req_load_y),
      .req_load_z (req_load_z),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (rsp_sample),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic longint clip(input longint v);
      if (v > longint'(SAT_MAX)) return longint'(SAT_MAX);
      if (v < longint'(SAT_MIN)) return longint'(SAT_MIN);
      return v;
   endfunction

   function automatic longint fmul(input longint a, input longint b);
      return clip((a * b) >>> FRAC_W);
   endfunction

   function automatic void lorenz_slope(input longint x, input longint y, input longint z,
                                        output longint fx, output longint fy,
                                        output longint fz);
      fx = fmul(sigma, clip(y - x));
      fy = clip(fmul(x, clip(rho - z)) - y);
      fz = clip(fmul(x, y) - fmul(z, beta));
   endfunction

   function automatic void heun_advance();
      longint fx, fy, fz, gx, gy, gz, ex, ey, ez;
      lorenz_slope(pos_x, pos_y, pos_z, fx, fy, fz);
      ex = clip(pos_x + fmul(dt_q, fx));
      ey = clip(pos_y + fmul(dt_q, fy));
      ez = clip(pos_z + fmul(dt_q, fz));
      lorenz_slope(ex, ey, ez, gx, gy, gz);
      pos_x = clip(pos_x + ((dt_q * (fx + gx)) >>> FRAC1_W));
      pos_y = clip(pos_y + ((dt_q * (fy + gy)) >>> FRAC1_W));
      pos_z = clip(pos_z + ((dt_q * (fz + gz)) >>> FRAC1_W));
   endfunction

   function automatic longint chosen_coord();
      case (dim_sel)
         DIM_Y: return pos_y;
         DIM_Z: return pos_z;
         default: return pos_x;
      endcase
   endfunction

   function automatic longint unit_clamp(input logic [DATA_W-1:0] data);
      longint s;
      s = longint'(data[FRAC1_W-1:0]);
      return (s > UNIT_Q) ? UNIT_Q : s;
   endfunction

   function automatic void apply_csr(input logic [CSR_W-1:0] idx,
                                     input logic [DATA_W-1:0] data);
      case (idx)
         CSR_COEF_A: sigma = longint'($signed(data));
         CSR_COEF_R: rho = longint'($signed(data));
         CSR_COEF_C: beta = longint'($signed(data));
         CSR_STEP_DT: dt_q = unit_clamp(data);
         CSR_DIM_SELECT: dim_sel = data[DIM_W-1:0];
         CSR_INTERP_STEP: interp_inc = unit_clamp(data);
         default: ;
      endcase
   endfunction

   function automatic void predict_sample(input lorenz_req_type rq);
      longint smp;
      if (rq.mode == MODE_LOAD) begin
         pos_x = longint'($signed(rq.load_x));
         pos_y = longint'($signed(rq.load_y));
         pos_z = longint'($signed(rq.load_z));
      end else begin
         if (interp_inc == 0) begin
            heun_advance();
            smp = chosen_coord();
         end else begin
            phase_q = phase_q + interp_inc;
            if (phase_q >= UNIT_Q) begin
               heun_advance();
               src_val = tgt_val;
               tgt_val = chosen_coord();
               dlt_val = tgt_val - src_val;
               phase_q = phase_q - UNIT_Q;
            end
            smp = clip(src_val + ((phase_q * dlt_val) >>> FRAC_W));
         end
         awaited_samples.push_back(smp[DATA_W-1:0]);
      end
   endfunction

   function automatic void log_fault(input string what);
      fault_count++;
      if (fault_count <= 10) begin
         $display("tb: ERROR at %0t: %s", $time, what);
      end
   endfunction

   function automatic logic [DATA_W-1:0] pick_word(input int lo, input int hi);
      case ($urandom_range(0, 11))
         0: return SAT_MAX;
         1: return SAT_MIN;
         2: return '0;
         3: return '1;
         4, 5: return $urandom;
         default: return lo + int'($urandom_range(0, hi - lo));
      endcase
   endfunction

   function automatic void queue_item(input logic mode, input logic [DATA_W-1:0] x,
                                      input logic [DATA_W-1:0] y,
                                      input logic [DATA_W-1:0] z);
      pending.push_back({mode, x, y, z});
   endfunction

   // Request driver: presents queued requests with a random gap after each acceptance.
   always @(posedge clock) begin
      lorenz_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_sample({req_mode, req_load_x, req_load_y, req_load_z});
            requests_taken++;
            if (req_mode == MODE_LOAD) begin
               loads_taken++;
            end
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending.size() != 0) begin
               nxt = pending.pop_front();
               req_mode <= nxt.mode;
               req_load_x <= nxt.load_x;
               req_load_y <= nxt.load_y;
               req_load_z <= nxt.load_z;
               req_valid <= 1'b1;
               req_gap <= req_steady ? 0 : int'($urandom_range(0, 17));
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Sample monitor: checks each accepted sample and stalls for a random time after it.
   always @(posedge clock) begin
      logic signed [DATA_W-1:0] want;
      int                       s;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_samples.size() == 0) begin
               log_fault($sformatf("sample %0d with no tick outstanding", rsp_sample));
            end else begin
               want = awaited_samples.pop_front();
               samples_checked++;
               if (rsp_sample !== want) begin
                  log_fault($sformatf("sample expected %0d (0x%08h), got %0d (0x%08h)",
                                      want, want, rsp_sample, rsp_sample));
               end
            end
            s = rsp_steady ? 0 : int'($urandom_range(0, 17));
            rsp_ready <= (s == 0);
            rsp_stall <= s;
         end else if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= (rsp_stall == 1);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic csr_write(input logic [CSR_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, data);
      csr_writes++;
   endtask

   task automatic write_settings(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] r,
                                 input logic [DATA_W-1:0] c, input logic [DATA_W-1:0] dt_w,
                                 input logic [DATA_W-1:0] dim_w,
                                 input logic [DATA_W-1:0] ip_w, input bit spare);
      @(posedge clock);
      if (spare) begin
         csr_write(CSR_SPARE_LO, $urandom);
         csr_write(CSR_SPARE_HI, $urandom);
      end
      csr_write(CSR_COEF_A, a);
      csr_write(CSR_COEF_R, r);
      csr_write(CSR_COEF_C, c);
      csr_write(CSR_STEP_DT, dt_w);
      csr_write(CSR_DIM_SELECT, dim_w);
      csr_write(CSR_INTERP_STEP, ip_w);
      csr_valid <= 1'b0;
      settings_used++;
      @(negedge clock);
   endtask

   task automatic settle();
      @(negedge clock);
      while (pending.size() != 0 || req_valid || awaited_samples.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int ph;
      int k;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_item(MODE_TICK, $urandom, $urandom, $urandom);
      queue_item(MODE_TICK, $urandom, $urandom, $urandom);
      queue_item(MODE_TICK, $urandom, $urandom, $urandom);
      queue_item(MODE_LOAD, SAT_MAX, SAT_MIN, '0);
      queue_item(MODE_TICK, '0, '0, '0);
      queue_item(MODE_TICK, '1, '1, '1);
      queue_item(MODE_LOAD, SAT_MIN, SAT_MAX, '1);
      queue_item(MODE_TICK, $urandom, $urandom, $urandom);
      queue_item(MODE_LOAD, ONE_WORD, ONE_WORD, ONE_WORD);
      queue_item(MODE_TICK, $urandom, $urandom, $urandom);
      settle();

      // Extreme coefficients, a step above one that must clamp, and writes to spare indexes.
      write_settings(SAT_MAX, SAT_MIN, SAT_MAX, '1, DATA_W'(DIM_Y), '0, 1'b1);
      queue_item(MODE_TICK, $urandom, $urandom, $urandom);
      queue_item(MODE_LOAD, '1, '0, 32'd1);
      queue_item(MODE_TICK, $urandom, $urandom, $urandom);
      queue_item(MODE_TICK, $urandom, $urandom, $urandom);
      settle();

      // Selector of three falls back to x; an increment above one steps on every tick.
      write_settings(SAT_MIN, '0, SAT_MIN, '0, '1, '1, 1'b0);
      queue_item(MODE_TICK, $urandom, $urandom, $urandom);
      queue_item(MODE_LOAD, 3 <<< FRAC_W, -(2 <<< FRAC_W), 5 <<< FRAC_W);
      queue_item(MODE_TICK, $urandom, $urandom, $urandom);
      queue_item(MODE_TICK, $urandom, $urandom, $urandom);
      settle();

      write_settings(COEF_A_RESET, COEF_R_RESET, COEF_C_RESET, DATA_W'(DT_RESET),
                     DATA_W'(DIM_Z), ONE_WORD >> 2, 1'b0);
      queue_item(MODE_LOAD, ONE_WORD, ONE_WORD, 20 <<< FRAC_W);
      for (k = 0; k < 6; k++) begin
         queue_item(MODE_TICK, $urandom, $urandom, $urandom);
      end

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         write_settings(pick_word(0, 20 <<< FRAC_W), pick_word(0, 50 <<< FRAC_W),
                        pick_word(0, 8 <<< FRAC_W), pick_word(1, int'(UNIT_Q / 32)),
                        $urandom,
                        ($urandom_range(0, 2) == 0) ? DATA_W'(0) : pick_word(1, int'(UNIT_Q)),
                        ($urandom_range(0, 3) == 0));
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 99) < 15) begin
               queue_item(MODE_LOAD, pick_word(-(40 <<< FRAC_W), 40 <<< FRAC_W),
                          pick_word(-(40 <<< FRAC_W), 40 <<< FRAC_W),
                          pick_word(-(10 <<< FRAC_W), 60 <<< FRAC_W));
            end else begin
               queue_item(MODE_TICK, $urandom, $urandom, $urandom);
            end
         end
      end
      settle();

      $display("tb: %0d requests taken, %0d of them position loads; %0d samples checked",
               requests_taken, loads_taken, samples_checked);
      $display("tb: %0d register writes across %0d settings, %0d mismatches",
               csr_writes, settings_used, fault_count);
      if (fault_count == 0 && awaited_samples.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/lho_pkg.sv
hw/rtl/lho_datapath.sv
hw/rtl/lho_sequencer.sv
hw/rtl/lorenz_heun_oscillator.sv
dv/tb_top.sv
